// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define RAGMT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ragmt assertion failed");

// The condition must never be true outside reset.
`define RAGMT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ragmt forbidden condition seen");

`endif

// ===== src/ragmt_pkg.sv =====
// ----------------------------------------------------------------------------
// ragmt_pkg
// Types and constants of the range add, global max segment tree.
// ----------------------------------------------------------------------------
package ragmt_pkg;

  localparam int POS_BITS   = 10;
  localparam int NODE_BITS  = POS_BITS + 1;
  localparam int NODES      = 1 << NODE_BITS;
  localparam int COUNT_BITS = 17;
  localparam int WORD_BITS  = 2 * COUNT_BITS;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [NODE_BITS-1:0]  node_addr_t;
  typedef logic [WORD_BITS-1:0]  node_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_CHK,
    ST_A_LWR,
    ST_A_CHK2,
    ST_A_RWR,
    ST_U_RD0,
    ST_U_RD1,
    ST_U_RD2,
    ST_U_WR,
    ST_F_RD,
    ST_F_OUT
  } state_t;

  typedef struct packed {
    logic       we;
    node_addr_t waddr;
    node_word_t wdata;
    node_addr_t raddr;
  } mem_req_t;

endpackage

// ===== src/range_add_global_max_tree_unit.sv =====
// ----------------------------------------------------------------------------
// range_add_global_max_tree_unit
// Segment tree with lazy range add of plus or minus one and a global max.
// ----------------------------------------------------------------------------
// After reset the unit clears all 2048 tree nodes, one per cycle, with busy high.
// An item with low <= high applies the add level by level, then rebuilds
// the maxima node by node along the two boundary paths; every item then
// reads the root. One item is in work at a time.
// The result shows on out_valid for one cycle as the item completes.
module range_add_global_max_tree_unit import ragmt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [POS_BITS-1:0] in_range_low,
  input  logic [POS_BITS-1:0] in_range_high,
  input  logic                in_is_open,
  output logic                out_valid,
  output count_t              out_current_max,
  output count_t              out_best_max
);

  mem_req_t   mem_req;
  node_word_t mem_rdata;

  ragmt_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_range_low    (in_range_low),
    .in_range_high   (in_range_high),
    .in_is_open      (in_is_open),
    .out_valid       (out_valid),
    .out_current_max (out_current_max),
    .out_best_max    (out_best_max),
    .mem_req         (mem_req),
    .mem_rdata       (mem_rdata)
  );

  ragmt_mem u_mem (
    .clk       (clk),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

endmodule

// ===== src/ragmt_mem.sv =====
// ----------------------------------------------------------------------------
// ragmt_mem
// Node store: one word per tree node holding the subtree maximum and the
// pending add, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module ragmt_mem import ragmt_pkg::*; (
  input  logic       clk,
  input  mem_req_t   mem_req,
  output node_word_t mem_rdata
);

  node_word_t mem [NODES];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    mem_rdata <= mem[mem_req.raddr];
  end

endmodule

// ===== src/ragmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ragmt_ctrl
// Sequencer: for a non-empty range, applies the add to the covering nodes
// level by level and rebuilds the maxima on both boundary paths; then reports the root.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ragmt_ctrl import ragmt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [POS_BITS-1:0] in_range_low,
  input  logic [POS_BITS-1:0] in_range_high,
  input  logic                in_is_open,
  output logic                out_valid,
  output count_t              out_current_max,
  output count_t              out_best_max,
  output mem_req_t            mem_req,
  input  node_word_t          mem_rdata
);

  state_t                  state_r, state_nxt;
  node_addr_t              clr_r;
  logic [NODE_BITS:0]      l_r, r_r, rm1;
  logic [POS_BITS-1:0]     low_r, high_r;
  logic [POS_BITS-1:0]     node_r;
  logic                    path_r;
  count_t                  delta_r, left_r, cmax_r, best_r;
  count_t                  rd_max, rd_pend;

  assign rm1     = r_r - 1'b1;
  assign rd_max  = mem_rdata[WORD_BITS-1:COUNT_BITS];
  assign rd_pend = mem_rdata[COUNT_BITS-1:0];
  assign busy    = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (clr_r == node_addr_t'(NODES - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          state_nxt = (in_range_low <= in_range_high) ? ST_A_CHK : ST_F_RD;
        end
      end
      ST_A_CHK: begin
        if (l_r >= r_r) state_nxt = ST_U_RD0;
        else if (l_r[0]) state_nxt = ST_A_LWR;
        else state_nxt = ST_A_CHK2;
      end
      ST_A_LWR:  state_nxt = ST_A_CHK2;
      ST_A_CHK2: state_nxt = r_r[0] ? ST_A_RWR : ST_A_CHK;
      ST_A_RWR:  state_nxt = ST_A_CHK;
      ST_U_RD0:  state_nxt = ST_U_RD1;
      ST_U_RD1:  state_nxt = ST_U_RD2;
      ST_U_RD2:  state_nxt = ST_U_WR;
      ST_U_WR: begin
        if (node_r == POS_BITS'(1) && path_r) state_nxt = ST_F_RD;
        else state_nxt = ST_U_RD0;
      end
      ST_F_RD:   state_nxt = ST_F_OUT;
      ST_F_OUT:  state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_req = '0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_r;
      end
      ST_A_CHK:  mem_req.raddr = l_r[NODE_BITS-1:0];
      ST_A_LWR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = l_r[NODE_BITS-1:0];
        mem_req.wdata = {rd_max + delta_r, rd_pend + delta_r};
      end
      ST_A_CHK2: mem_req.raddr = rm1[NODE_BITS-1:0];
      ST_A_RWR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = rm1[NODE_BITS-1:0];
        mem_req.wdata = {rd_max + delta_r, rd_pend + delta_r};
      end
      ST_U_RD0:  mem_req.raddr = {node_r, 1'b0};
      ST_U_RD1:  mem_req.raddr = {node_r, 1'b1};
      ST_U_RD2:  mem_req.raddr = {1'b0, node_r};
      ST_U_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = {1'b0, node_r};
        mem_req.wdata = {cmax_r + rd_pend, rd_pend};
      end
      ST_F_RD:   mem_req.raddr = node_addr_t'(1);
      default:   mem_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_r     <= '0;
      best_r    <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_valid <= 1'b0;
      if (state_r == ST_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == ST_F_OUT) begin
        out_valid       <= 1'b1;
        out_current_max <= rd_max;
        if ($signed(rd_max) > $signed(best_r)) begin
          best_r       <= rd_max;
          out_best_max <= rd_max;
        end else begin
          out_best_max <= best_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        low_r   <= in_range_low;
        high_r  <= in_range_high;
        delta_r <= in_is_open ? count_t'(1) : '1;
        l_r     <= {2'b01, in_range_low};
        r_r     <= {2'b01, in_range_high} + 1'b1;
      end
      ST_A_CHK: begin
        node_r <= {1'b1, low_r[POS_BITS-1:1]};
        path_r <= 1'b0;
      end
      ST_A_LWR:  l_r <= l_r + 1'b1;
      ST_A_CHK2: begin
        if (!r_r[0]) begin
          l_r <= l_r >> 1;
          r_r <= r_r >> 1;
        end
      end
      ST_A_RWR: begin
        l_r <= l_r >> 1;
        r_r <= rm1 >> 1;
      end
      ST_U_RD1:  left_r <= rd_max;
      ST_U_RD2:  cmax_r <= ($signed(rd_max) > $signed(left_r)) ? rd_max : left_r;
      ST_U_WR: begin
        if (node_r == POS_BITS'(1)) begin
          node_r <= {1'b1, high_r[POS_BITS-1:1]};
          path_r <= 1'b1;
        end else begin
          node_r <= node_r >> 1;
        end
      end
      default: begin
      end
    endcase
  end

  `RAGMT_ASSERT(a_best_nonneg, out_valid |-> !out_best_max[COUNT_BITS-1])
  `RAGMT_ASSERT(a_best_ge_cur, out_valid |-> ($signed(out_best_max) >= $signed(out_current_max)))
  `RAGMT_ASSERT(a_out_from_root, out_valid |-> ($past(state_r) == ST_F_OUT))
  `RAGMT_NEVER(a_idle_no_write, (state_r == ST_IDLE) && mem_req.we)

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Range add, global max segment tree testbench
// Drives range add items through the command port with random gaps and
// checks every result against a behavioral segment tree of its own.
// ----------------------------------------------------------------------------
module testbench;
  import ragmt_pkg::*;

  localparam int SPAN      = 1 << POS_BITS;
  localparam int TREE_SIZE = 4 * SPAN;

  typedef struct {
    logic [POS_BITS-1:0] low;
    logic [POS_BITS-1:0] high;
    logic                open;
    int                  gap;
    bit                  drain;
  } range_item_t;

  typedef struct {
    count_t cur;
    count_t best;
  } coverage_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [POS_BITS-1:0] in_range_low = '0;
  logic [POS_BITS-1:0] in_range_high = '0;
  logic                in_is_open = 1'b0;
  logic                out_valid;
  count_t              out_current_max;
  count_t              out_best_max;

  range_item_t pending_items[$];
  range_item_t driven_item;
  coverage_t   expected_cov[$];
  count_t      tree_max[TREE_SIZE];
  count_t      tree_add[TREE_SIZE];
  count_t      best_cov = '0;
  int          errors = 0;
  int          opens = 0;
  int          closes = 0;
  int          empties = 0;
  int          results_seen = 0;
  int          gap_left = 0;
  bit          gap_loaded = 1'b0;

  range_add_global_max_tree_unit DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_range_low(in_range_low), .in_range_high(in_range_high),
    .in_is_open(in_is_open), .out_valid(out_valid),
    .out_current_max(out_current_max), .out_best_max(out_best_max)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic apply_range(int node, int lo, int hi, int a, int b, count_t d);
    int     mid;
    count_t child;
    if (node >= TREE_SIZE || b < lo || a > hi) return;
    if (a <= lo && hi <= b) begin
      tree_max[node] = tree_max[node] + d;
      tree_add[node] = tree_add[node] + d;
      return;
    end
    mid = lo + (hi - lo) / 2;
    apply_range(2 * node, lo, mid, a, b, d);
    apply_range(2 * node + 1, mid + 1, hi, a, b, d);
    if (2 * node + 1 >= TREE_SIZE) return;
    child = ($signed(tree_max[2*node]) > $signed(tree_max[2*node+1])) ?
            tree_max[2*node] : tree_max[2*node+1];
    tree_max[node] = child + tree_add[node];
  endtask

  task automatic predict_coverage(range_item_t it);
    coverage_t c;
    count_t    d;
    d = it.open ? count_t'(1) : '1;
    if (it.low <= it.high) apply_range(1, 0, SPAN - 1, it.low, it.high, d);
    else empties++;
    if (it.open) opens++;
    else closes++;
    if ($signed(tree_max[1]) > $signed(best_cov)) best_cov = tree_max[1];
    c.cur  = tree_max[1];
    c.best = best_cov;
    expected_cov.push_back(c);
  endtask

  always @(posedge clk) begin
    logic next_start;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        predict_coverage(driven_item);
        void'(pending_items.pop_front());
        next_start = 1'b0;
        gap_loaded = 1'b0;
      end
      if (!next_start && pending_items.size() > 0) begin
        if (!gap_loaded) begin
          gap_left = pending_items[0].gap;
          gap_loaded = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(pending_items[0].drain && expected_cov.size() > 0)) begin
          driven_item = pending_items[0];
          in_range_low <= pending_items[0].low;
          in_range_high <= pending_items[0].high;
          in_is_open <= pending_items[0].open;
          next_start = 1'b1;
        end
      end
      start <= next_start;
    end
  end

  always @(posedge clk) begin
    coverage_t c;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_cov.size() == 0) begin
        $error("Result with no item outstanding");
        errors++;
      end else begin
        c = expected_cov.pop_front();
        if (out_current_max !== c.cur) begin
          $error("current_max expected %0d actual %0d", $signed(c.cur),
                 $signed(out_current_max));
          errors++;
        end
        if (out_best_max !== c.best) begin
          $error("best_max expected %0d actual %0d", $signed(c.best),
                 $signed(out_best_max));
          errors++;
        end
      end
    end
  end

  function automatic void add_item(int lo, int hi, bit op, int gap, bit drain);
    range_item_t it;
    it.low = lo;
    it.high = hi;
    it.open = op;
    it.gap = gap;
    it.drain = drain;
    pending_items.push_back(it);
  endfunction

  initial begin
    int live_lo[$];
    int live_hi[$];
    int lo, hi, k, g, kind;
    foreach (tree_max[i]) begin
      tree_max[i] = '0;
      tree_add[i] = '0;
    end
    add_item(0, SPAN - 1, 1, 0, 0);
    add_item(0, 0, 1, 0, 0);
    add_item(SPAN - 1, SPAN - 1, 1, 3, 0);
    add_item(5, 9, 1, 0, 0);
    add_item(7, 7, 1, 1, 0);
    add_item(9, 5, 1, 0, 0);
    add_item(SPAN - 1, 0, 0, 0, 0);
    add_item(7, 7, 0, 2, 0);
    add_item(5, 9, 0, 0, 0);
    add_item(SPAN - 1, SPAN - 1, 0, 0, 0);
    add_item(0, 0, 0, 0, 0);
    add_item(0, SPAN - 1, 0, 0, 1);
    add_item(0, SPAN - 1, 0, 0, 0);
    add_item(10, 20, 0, 0, 0);
    add_item(10, 20, 1, 0, 0);
    add_item(0, SPAN - 1, 1, 0, 0);
    add_item(0, SPAN - 1, 1, 0, 0);
    add_item(341, 682, 1, 5, 0);
    add_item(682, 341, 0, 0, 0);
    add_item(511, 512, 1, 0, 0);
    for (int i = 0; i < 1130; i++) begin
      g = (i >= 300 && i < 400) ? 0 : $urandom_range(0, 19);
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        if (live_lo.size() == 0 || ($urandom_range(0, 1) && live_lo.size() < 40)) begin
          case ($urandom_range(0, 2))
            0: begin lo = $urandom_range(0, SPAN - 1); hi = lo; end
            1: begin lo = $urandom_range(0, SPAN - 1); hi = $urandom_range(lo, SPAN - 1); end
            default: begin
              lo = $urandom_range(0, SPAN - 1);
              hi = (lo + $urandom_range(0, 31) > SPAN - 1) ? SPAN - 1 :
                   lo + $urandom_range(0, 31);
            end
          endcase
          live_lo.push_back(lo);
          live_hi.push_back(hi);
          add_item(lo, hi, 1, g, 0);
        end else begin
          k = $urandom_range(0, live_lo.size() - 1);
          add_item(live_lo[k], live_hi[k], 0, g, 0);
          live_lo.delete(k);
          live_hi.delete(k);
        end
      end else begin
        add_item($urandom_range(0, SPAN - 1), $urandom_range(0, SPAN - 1),
                 $urandom_range(0, 1), g, i == 700);
      end
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_items.size() == 0 && expected_cov.size() == 0);
    repeat (200) @(posedge clk);
    $display("Covered %0d opening and %0d closing items, %0d with empty ranges,",
             opens, closes, empties);
    $display("and compared %0d results.", results_seen);
    if (errors == 0 && expected_cov.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("Some tests failed");
    $finish;
  end
endmodule
